[sv/iirf_pkg.sv]
// ----------------------------------------------------------------------------
// iirf_pkg
// Shared types, widths and the microprogram of the direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package iirf_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int CIDX_W     = 4;
  localparam int OUT_W      = 32;
  localparam int Y_W        = 48;   // Q32.16 output history
  localparam int FRAC_W     = 16;
  localparam int TAPS_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int BANK_SLOTS = 8;    // coefficient slots per bank on the index field

  // datapath widths
  localparam int MUL_B_W = 33;                  // signed operand of the shared multiplier
  localparam int PROD_W  = COEF_W + MUL_B_W;    // 65
  localparam int WIDE_W  = PROD_W + 1;          // product plus low partial
  localparam int LO_W    = 34;                  // floor(c*ylow / 2^16)
  localparam int ACC_W   = 60;
  localparam int FF_SHIFT = 12;                 // Q.28 -> Q.16
  localparam int LO_SHIFT = 16;

  // word function codes
  localparam logic FUNC_COEF   = 1'b0;
  localparam logic FUNC_FILTER = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TAPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_TAPS = 2'd1;

  // microprogram
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] ST_INIT    = 3'd0;
  localparam logic [PC_W-1:0] ST_FF_MUL  = 3'd1;
  localparam logic [PC_W-1:0] ST_FF_ACC  = 3'd2;
  localparam logic [PC_W-1:0] ST_FB_INIT = 3'd3;
  localparam logic [PC_W-1:0] ST_FB_LO   = 3'd4;
  localparam logic [PC_W-1:0] ST_FB_HI   = 3'd5;
  localparam logic [PC_W-1:0] ST_FB_ACC  = 3'd6;
  localparam logic [PC_W-1:0] ST_DONE    = 3'd7;

  typedef enum logic [1:0] {MUL_NONE, MUL_FF, MUL_FB_LO, MUL_FB_HI} mul_sel_t;
  typedef enum logic [1:0] {ACC_NONE, ACC_FF, ACC_FB} acc_op_t;
  typedef enum logic [2:0] {
    JMP_NONE, JMP_FF_ZERO, JMP_FB_ZERO, JMP_FF_MORE, JMP_FB_MORE
  } jmp_t;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  // one control word
  typedef struct packed {
    logic            acc_clr;
    logic            tap_clr;
    logic            tap_inc;
    logic            keep_lo;
    mul_sel_t        mul_sel;
    acc_op_t         acc_op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    logic            last;
  } ctrl_t;

  // datapath status for conditional jumps
  typedef struct packed {
    logic ff_zero;
    logic fb_zero;
    logic ff_more;
    logic fb_more;
  } stat_t;

  localparam ctrl_t CTRL_NOP = '{
    acc_clr: 1'b0, tap_clr: 1'b0, tap_inc: 1'b0, keep_lo: 1'b0,
    mul_sel: MUL_NONE, acc_op: ACC_NONE, jmp: JMP_NONE, target: ST_INIT, last: 1'b0
  };

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      ST_INIT: begin
        w.acc_clr = 1'b1;
        w.tap_clr = 1'b1;
        w.jmp     = JMP_FF_ZERO;
        w.target  = ST_FB_INIT;
      end
      ST_FF_MUL: begin
        w.mul_sel = MUL_FF;
      end
      ST_FF_ACC: begin
        w.acc_op  = ACC_FF;
        w.tap_inc = 1'b1;
        w.jmp     = JMP_FF_MORE;
        w.target  = ST_FF_MUL;
      end
      ST_FB_INIT: begin
        w.tap_clr = 1'b1;
        w.jmp     = JMP_FB_ZERO;
        w.target  = ST_DONE;
      end
      ST_FB_LO: begin
        w.mul_sel = MUL_FB_LO;
      end
      ST_FB_HI: begin
        w.keep_lo = 1'b1;
        w.mul_sel = MUL_FB_HI;
      end
      ST_FB_ACC: begin
        w.acc_op  = ACC_FB;
        w.tap_inc = 1'b1;
        w.jmp     = JMP_FB_MORE;
        w.target  = ST_FB_LO;
      end
      ST_DONE: begin
        w.last = 1'b1;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

endpackage

[sv/direct_form_iir_filter_unit.sv]
// ----------------------------------------------------------------------------
// direct_form_iir_filter_unit
// Direct-form-I IIR filter with run-time Q4.28 coefficients.
// ----------------------------------------------------------------------------
// A word with func set filters one unsigned sample and gives one result, the
// integer part of the Q32.16 output saturated to 32 bits; a word with func
// clear writes one coefficient without occupying the block and gives no
// result. All taps go through one shared multiplier under a microprogram: a
// sample occupies the block from acceptance to the final step of its run, and
// no further word is taken until that step is done. Each feedforward tap
// costs a multiply and an accumulate; each feedback tap two multiplies (low
// and high half of the 48-bit history) and an accumulate. A finished result
// waits in the output register while the next word is taken; the block only
// holds its final step if the previous result has still not been taken. The
// user must write tap counts through the configuration port only while no
// sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module direct_form_iir_filter_unit #(
  parameter int MAX_FF_TAPS = 8,
  parameter int MAX_FB_TAPS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  func,
  input  logic [iirf_pkg::CIDX_W-1:0]           coef_index,
  input  logic signed [iirf_pkg::COEF_W-1:0]    coef_value,
  input  logic [iirf_pkg::SAMPLE_W-1:0]         sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iirf_pkg::OUT_W-1:0]     filtered,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [iirf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [iirf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import iirf_pkg::*;

  ctrl_t                    ctrl;
  stat_t                    stat;
  logic                     busy;
  logic                     in_take;
  logic                     start;
  logic                     coef_we;
  logic                     step_en;
  logic                     done;
  logic [TAPS_W-1:0]        ff_taps;
  logic [TAPS_W-1:0]        fb_taps;
  logic signed [OUT_W-1:0]  result;

  // input handshake
  assign in_ready = !busy;
  assign in_take  = in_valid && in_ready;
  assign start    = in_take && (func == FUNC_FILTER);
  assign coef_we  = in_take && (func == FUNC_COEF);

  // hold the last step while the output register is still full
  assign step_en = !(ctrl.last && out_valid && !out_ready);
  assign done    = step_en && ctrl.last;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_taps <= TAPS_W'(4);
      fb_taps <= TAPS_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FF_TAPS: ff_taps <= cfg_data;
        CFG_FB_TAPS: fb_taps <= cfg_data;
        default: ;
      endcase
    end
  end

  iirf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .en    (step_en),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  iirf_datapath #(
    .MAX_FF (MAX_FF_TAPS),
    .MAX_FB (MAX_FB_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .en         (step_en),
    .ctrl       (ctrl),
    .stat       (stat),
    .ff_taps    (ff_taps),
    .fb_taps    (fb_taps),
    .coef_we    (coef_we),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .sample_we  (start),
    .sample     (sample),
    .result     (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) filtered <= result;
  end

endmodule

[sv/iirf_seq.sv]
// ----------------------------------------------------------------------------
// iirf_seq
// Microprogram sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module iirf_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            en,
  input  iirf_pkg::stat_t stat,
  output iirf_pkg::ctrl_t ctrl,
  output logic            busy
);
  import iirf_pkg::*;

  seq_state_t      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            taken;

  // jump condition
  always_comb begin
    unique case (ctrl.jmp)
      JMP_FF_ZERO: taken = stat.ff_zero;
      JMP_FB_ZERO: taken = stat.fb_zero;
      JMP_FF_MORE: taken = stat.ff_more;
      JMP_FB_MORE: taken = stat.fb_more;
      default:     taken = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (start) state_next = SEQ_RUN;
      SEQ_RUN:  if (en && ctrl.last) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    unique case (state)
      SEQ_RUN: begin
        ctrl = ucode(pc);
        busy = 1'b1;
      end
      default: begin
        ctrl = CTRL_NOP;
        busy = 1'b0;
      end
    endcase
  end

  // step counter
  always_comb begin
    pc_next = pc;
    if (state == SEQ_IDLE) begin
      pc_next = ST_INIT;
    end else if (en && !ctrl.last) begin
      pc_next = taken ? ctrl.target : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= ST_INIT;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule

[sv/iirf_datapath.sv]
// ----------------------------------------------------------------------------
// iirf_datapath
// Coefficient stores, sample and output histories, shared multiplier and
// accumulator, steered by the control word.
// ----------------------------------------------------------------------------
module iirf_datapath #(
  parameter int MAX_FF = 8,
  parameter int MAX_FB = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  iirf_pkg::ctrl_t                     ctrl,
  output iirf_pkg::stat_t                     stat,
  input  logic [iirf_pkg::TAPS_W-1:0]         ff_taps,
  input  logic [iirf_pkg::TAPS_W-1:0]         fb_taps,
  input  logic                                coef_we,
  input  logic [iirf_pkg::CIDX_W-1:0]         coef_index,
  input  logic signed [iirf_pkg::COEF_W-1:0]  coef_value,
  input  logic                                sample_we,
  input  logic [iirf_pkg::SAMPLE_W-1:0]       sample,
  output logic signed [iirf_pkg::OUT_W-1:0]   result
);
  import iirf_pkg::*;

  localparam int MAX_TAPS  = (MAX_FF > MAX_FB) ? MAX_FF : MAX_FB;
  localparam int T_W       = $clog2(MAX_TAPS + 1);
  localparam int FF_IDX_W  = $clog2(MAX_FF);
  localparam int FB_IDX_W  = (MAX_FB > 1) ? $clog2(MAX_FB) : 1;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-Y_W+1){1'b1}}, {(Y_W-1){1'b0}}};

  logic        [SAMPLE_W-1:0] x_hist [MAX_FF];
  logic signed [Y_W-1:0]      y_hist [MAX_FB];
  logic signed [COEF_W-1:0]   ff_coef [MAX_FF];
  logic signed [COEF_W-1:0]   fb_coef [MAX_FB];

  logic        [T_W-1:0]      tap;
  logic        [T_W-1:0]      nff, nfb;
  logic signed [COEF_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [LO_W-1:0]     lo_q;
  logic signed [WIDE_W-1:0]   fb_sum;
  logic signed [ACC_W-1:0]    acc;
  logic signed [Y_W-1:0]      y_sat;
  logic        [SAMPLE_W-1:0] x_tap;
  logic signed [Y_W-1:0]      y_tap;

  // tap counts clipped to the store depth
  always_comb begin
    nff = (ff_taps > MAX_FF) ? T_W'(MAX_FF) : T_W'(ff_taps);
    nfb = (fb_taps > MAX_FB) ? T_W'(MAX_FB) : T_W'(fb_taps);
  end

  // jump status
  always_comb begin
    stat.ff_zero = (nff == '0);
    stat.fb_zero = (nfb == '0);
    stat.ff_more = ({1'b0, tap} + 1'b1) < {1'b0, nff};
    stat.fb_more = ({1'b0, tap} + 1'b1) < {1'b0, nfb};
  end

  // tap operands
  assign x_tap = x_hist[tap[FF_IDX_W-1:0]];
  assign y_tap = y_hist[tap[FB_IDX_W-1:0]];

  // multiplier operand select
  always_comb begin
    mul_a = ff_coef[tap[FF_IDX_W-1:0]];
    mul_b = MUL_B_W'({1'b0, x_tap});
    case (ctrl.mul_sel)
      MUL_FB_LO: begin
        mul_a = fb_coef[tap[FB_IDX_W-1:0]];
        mul_b = MUL_B_W'({1'b0, y_tap[FRAC_W-1:0]});
      end
      MUL_FB_HI: begin
        mul_a = fb_coef[tap[FB_IDX_W-1:0]];
        mul_b = {y_tap[Y_W-1], y_tap[Y_W-1:FRAC_W]};
      end
      default: ;
    endcase
  end

  // feedback term: hi product plus floored low partial
  assign fb_sum = WIDE_W'(prod) + WIDE_W'(lo_q);

  // saturate to Q32.16
  always_comb begin
    if (acc > SAT_HI)      y_sat = SAT_HI[Y_W-1:0];
    else if (acc < SAT_LO) y_sat = SAT_LO[Y_W-1:0];
    else                   y_sat = acc[Y_W-1:0];
  end

  assign result = y_sat[Y_W-1:FRAC_W];

  // multiply, accumulate, tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
      acc <= '0;
    end else if (en) begin
      if (ctrl.tap_clr)      tap <= '0;
      else if (ctrl.tap_inc) tap <= tap + 1'b1;
      if (ctrl.acc_clr) begin
        acc <= '0;
      end else begin
        case (ctrl.acc_op)
          ACC_FF:  acc <= acc + ACC_W'(prod >>> FF_SHIFT);
          ACC_FB:  acc <= acc - ACC_W'(fb_sum >>> FF_SHIFT);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctrl.keep_lo) lo_q <= LO_W'(prod >>> LO_SHIFT);
    if (en && ctrl.mul_sel != MUL_NONE) prod <= mul_a * mul_b;
  end

  // feedforward store and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FF; i++) begin
        x_hist[i]  <= '0;
        ff_coef[i] <= '0;
      end
    end else begin
      if (sample_we) begin
        x_hist[0] <= sample;
        for (int i = 1; i < MAX_FF; i++) x_hist[i] <= x_hist[i-1];
      end
      for (int i = 0; i < MAX_FF; i++) begin
        if (coef_we && !coef_index[CIDX_W-1] && i < BANK_SLOTS &&
            int'(coef_index[CIDX_W-2:0]) == i)
          ff_coef[i] <= coef_value;
      end
    end
  end

  // feedback store and output history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FB; i++) begin
        y_hist[i]  <= '0;
        fb_coef[i] <= '0;
      end
    end else begin
      if (en && ctrl.last) begin
        y_hist[0] <= y_sat;
        for (int i = 1; i < MAX_FB; i++) y_hist[i] <= y_hist[i-1];
      end
      for (int i = 0; i < MAX_FB; i++) begin
        if (coef_we && coef_index[CIDX_W-1] && i < BANK_SLOTS &&
            int'(coef_index[CIDX_W-2:0]) == i)
          fb_coef[i] <= coef_value;
      end
    end
  end

endmodule

[sv/iirf_checker.sv]
// ----------------------------------------------------------------------------
// iirf_checker
// Port-level checks on the filter's handshakes and occupancy.
// ----------------------------------------------------------------------------
module iirf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                func,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [iirf_pkg::OUT_W-1:0]   filtered
);
  import iirf_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("result word changed or dropped while stalled");

  // a sample word occupies the block
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_FILTER |=> !in_ready)
    else $error("input still ready after a sample word");

  // a coefficient word does not
  a_coef_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_COEF |=> in_ready)
    else $error("coefficient word blocked the input");

  // a result only appears at the end of a sample's run
  a_result_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word without a sample in flight");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind direct_form_iir_filter_unit iirf_checker u_iirf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .filtered  (filtered)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the direct-form-I IIR filter unit.
// ----------------------------------------------------------------------------
// Coefficient and sample words go in through the data channel, and tap counts
// through the configuration channel. A bit-true copy of the filter, kept
// inside this bench, works out the integer output of every accepted sample.
// The outputs are queued and compared in order with the words that the unit
// hands out. Directed words cover the coefficient and sample extremes,
// saturation in both directions, the FIR and zero-feedforward settings, tap
// counts above the store depth and the unused register indexes. Long random
// streams follow under three idling patterns, with one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import iirf_pkg::*;

  localparam int FF_DEPTH = 8;
  localparam int FB_DEPTH = 8;
  localparam logic [CIDX_W-1:0] FB_SLOT_BASE = 4'd8;
  // register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam longint Y_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Y_MIN = -Y_MAX - 1;
  localparam int SETTLE_CYCLES = 48;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       func = FUNC_COEF;
  logic [CIDX_W-1:0]          coef_index = '0;
  logic signed [COEF_W-1:0]   coef_value = '0;
  logic [SAMPLE_W-1:0]        sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_W-1:0]    filtered;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // bench copy of the filter state
  logic [TAPS_W-1:0]          ff_taps;
  logic [TAPS_W-1:0]          fb_taps;
  logic [SAMPLE_W-1:0]        x_hist [FF_DEPTH];
  logic signed [Y_W-1:0]      y_hist [FB_DEPTH];
  logic signed [COEF_W-1:0]   b_coef [FF_DEPTH];
  logic signed [COEF_W-1:0]   a_coef [FB_DEPTH];

  logic signed [OUT_W-1:0]    expected_out [$];
  logic signed [OUT_W-1:0]    want;
  int                         mismatch_count = 0;
  int                         words_sent = 0;
  int                         send_idle_pct = 0;
  int                         recv_idle_pct = 0;
  int                         hold_req = 0;
  int                         hold_left = 0;

  direct_form_iir_filter_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .filtered   (filtered),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // run limit, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("direct_form_iir_filter_unit regression: fail");
    $finish;
  end

  // filter one word through the bench copy; returns 1 when an output is due
  function automatic logic filter_word(input logic fn, input logic [CIDX_W-1:0] idx,
                                       input logic signed [COEF_W-1:0] val,
                                       input logic [SAMPLE_W-1:0] smp,
                                       output logic signed [OUT_W-1:0] y_int);
    logic signed [79:0] acc;
    logic signed [79:0] cw;
    logic signed [79:0] dw;
    logic signed [Y_W-1:0] y_new;
    int nff;
    int nfb;
    y_int = '0;
    if (fn == FUNC_COEF) begin
      if (idx < FB_SLOT_BASE) b_coef[idx[CIDX_W-2:0]] = val;
      else a_coef[idx[CIDX_W-2:0]] = val;
      return 1'b0;
    end
    for (int i = FF_DEPTH - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
    x_hist[0] = smp;
    nff = (ff_taps > FF_DEPTH) ? FF_DEPTH : int'(ff_taps);
    nfb = (fb_taps > FB_DEPTH) ? FB_DEPTH : int'(fb_taps);
    acc = '0;
    // feedforward products floored from Q.28 to Q.16
    for (int i = 0; i < nff; i++) begin
      cw = 80'(b_coef[i]);
      dw = {64'd0, x_hist[i]};
      acc = acc + ((cw * dw) >>> 12);
    end
    // feedback products floored from Q.44 to Q.16, subtracted
    for (int i = 0; i < nfb; i++) begin
      cw = 80'(a_coef[i]);
      dw = 80'(y_hist[i]);
      acc = acc - ((cw * dw) >>> 28);
    end
    if (acc > Y_MAX) acc = 80'(Y_MAX);
    else if (acc < Y_MIN) acc = 80'(Y_MIN);
    y_new = acc[Y_W-1:0];
    for (int i = FB_DEPTH - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = y_new;
    y_int = y_new[Y_W-1:FRAC_W];
    return 1'b1;
  endfunction

  // offer one word, hold it until taken, then log its expected output
  task automatic send_word(input logic fn, input logic [CIDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] val,
                           input logic [SAMPLE_W-1:0] smp);
    logic has_out;
    logic signed [OUT_W-1:0] y_int;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    coef_index <= idx;
    coef_value <= val;
    sample     <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_out = filter_word(fn, idx, val, smp, y_int);
    if (has_out) expected_out.push_back(y_int);
    words_sent++;
  endtask

  // coefficient word; the sample field carries noise
  task automatic send_coef(input logic [CIDX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
    send_word(FUNC_COEF, idx, val, SAMPLE_W'($urandom));
  endtask

  // sample word; index and value carry noise
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    send_word(FUNC_FILTER, CIDX_W'($urandom), $urandom, smp);
  endtask

  // drop valid, let all outputs come back, then let the unit settle
  task automatic wait_for_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FF_TAPS) ff_taps = data;
    else if (idx == CFG_FB_TAPS) fb_taps = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Q4.28: mild values keep the feedback loop stable, wild ones span all bits
  function automatic logic signed [COEF_W-1:0] rand_coef(input bit wild, input bit feedback);
    int span;
    if (wild) return $urandom;
    span = feedback ? 32'h0200_0000 : 32'h1000_0000;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample;
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  // tap counts: mostly in range, now and then zero or above the depth
  function automatic logic [TAPS_W-1:0] rand_taps(input bit feedback);
    int r;
    r = $urandom_range(99);
    if (r < (feedback ? 15 : 5)) return '0;
    if (r < (feedback ? 25 : 15)) return TAPS_W'($urandom_range(9, 15));
    return TAPS_W'($urandom_range(1, 8));
  endfunction

  // output side: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each output word with the oldest expected value
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output word: filtered %0d (0x%08h)", filtered, filtered);
      end else begin
        want = expected_out.pop_front();
        if (filtered !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("filtered mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                     want, want, filtered, filtered);
        end
      end
    end
  end

  // reset taps with all coefficients zero
  task automatic test_reset_state;
    send_sample('1);
    send_sample('0);
  endtask

  // full-scale coefficients; feedback of -8 and +8 drives both saturations
  task automatic test_coef_extremes;
    send_coef(4'd0, 32'sh7FFF_FFFF);
    send_coef(4'd7, 32'sh8000_0000);
    send_coef(FB_SLOT_BASE, 32'sh8000_0000);
    send_coef(4'd15, 32'sh7FFF_FFFF);
    repeat (5) send_sample('1);
    send_sample('0);
    send_coef(FB_SLOT_BASE, 32'sh7FFF_FFFF);
    repeat (3) send_sample('0);
  endtask

  // tap settings incl. FIR, no feedforward, counts above depth, spare indexes
  task automatic test_tap_settings;
    logic [TAPS_W-1:0] ff_set [5] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2};
    logic [TAPS_W-1:0] fb_set [5] = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd9};
    wait_for_results;
    write_reg(CFG_SPARE_LO, 4'hF);
    write_reg(CFG_SPARE_HI, 4'h0);
    for (int k = 0; k < 5; k++) begin
      wait_for_results;
      write_reg(CFG_FF_TAPS, ff_set[k]);
      write_reg(CFG_FB_TAPS, fb_set[k]);
      send_sample('1);
      send_sample(16'h5A5A);
    end
  endtask

  // random settings, coefficient sets and sample runs
  task automatic test_random_stream(input int n_words);
    int stop_at;
    int run_len;
    bit wild;
    logic [CIDX_W-1:0] idx;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      wait_for_results;
      write_reg(CFG_FF_TAPS, rand_taps(1'b0));
      write_reg(CFG_FB_TAPS, rand_taps(1'b1));
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CFG_DATA_W'($urandom));
      wild = ($urandom_range(99) < 12);
      // fresh coefficient set in one burst
      if ($urandom_range(1) == 1) begin
        for (int k = 0; k < FF_DEPTH + FB_DEPTH; k++) begin
          idx = CIDX_W'(k);
          send_coef(idx, rand_coef(wild, idx >= FB_SLOT_BASE));
        end
      end
      run_len = $urandom_range(30, 80);
      repeat (run_len) begin
        if ($urandom_range(99) < 8) begin
          idx = CIDX_W'($urandom);
          send_coef(idx, rand_coef(wild, idx >= FB_SLOT_BASE));
        end else begin
          send_sample(rand_sample());
        end
      end
    end
  endtask

  // long output stall while samples keep coming, then a full drain
  task automatic test_output_stall;
    wait_for_results;
    write_reg(CFG_FF_TAPS, 4'd2);
    write_reg(CFG_FB_TAPS, 4'd1);
    @(posedge clk);
    hold_req = 400;
    repeat (14) send_sample(rand_sample());
    wait_for_results;
  endtask

  initial begin
    ff_taps = 4'd4;
    fb_taps = 4'd3;
    for (int i = 0; i < FF_DEPTH; i++) begin
      x_hist[i] = '0;
      b_coef[i] = '0;
    end
    for (int i = 0; i < FB_DEPTH; i++) begin
      y_hist[i] = '0;
      a_coef[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 21;
    recv_idle_pct = 78;
    test_reset_state;
    test_coef_extremes;
    test_tap_settings;
    test_random_stream(630);

    send_idle_pct = 78;
    recv_idle_pct = 21;
    test_random_stream(630);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(620);
    test_output_stall;

    wait_for_results;
    if (mismatch_count == 0 && expected_out.size() == 0) begin
      $display("direct_form_iir_filter_unit regression: pass");
    end else begin
      $display("direct_form_iir_filter_unit regression: fail");
    end
    $finish;
  end

endmodule
